@@ rtl/sle_pkg.sv @@
// ============================================================================
// sle_pkg: shared types and constants of the serial line editor
// Request and result beats, the command word between front and back, and the
// character codes the editor reacts to.
// ============================================================================
package sle_pkg;

  // Request kinds carried in req_type
  typedef enum logic [1:0] {
    REQ_RX    = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_kind_e;

  // Result kinds carried in out_kind
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Character codes
  localparam logic [7:0] CODE_BS      = 8'h08;
  localparam logic [7:0] CODE_DEL     = 8'h7f;
  localparam logic [7:0] CODE_ESC     = 8'h1b;
  localparam logic [7:0] CODE_CR      = 8'h0d;
  localparam logic [7:0] CODE_LF      = 8'h0a;
  localparam logic [7:0] CODE_CARET   = 8'h5e;
  localparam logic [7:0] CODE_BRACKET = 8'h5b;

  // Input beat
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } req_t;

  // Result beat
  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
    logic       end_of_line;
    logic [6:0] line_length;
    logic       last;
  } rsp_t;

  // One classified request, worth one or two result beats
  typedef struct packed {
    logic       is_read;
    logic       two;
    logic       eol;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [6:0] line_length;
  } cmd_t;

  // Front sequencer states
  typedef enum logic {
    FRONT_RUN,
    FRONT_ESC2
  } front_state_e;

endpackage

@@ rtl/sle_front.sv @@
// ============================================================================
// sle_front: request intake and line state
// Classify each request, update the line count, write and read the line store,
// and hand a command word to the queue.
// ============================================================================
module sle_front #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  sle_pkg::req_t req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_full_i,
  output sle_pkg::cmd_t cmd_o
);

  localparam int CW = $clog2(LINE_CAPACITY + 1);
  localparam int AW = $clog2(LINE_CAPACITY);
  localparam logic [CW-1:0] CAP_C   = CW'(LINE_CAPACITY);
  localparam logic [CW-1:0] CAP_M1  = CW'(LINE_CAPACITY - 1);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  logic [7:0] mem [LINE_CAPACITY];

  sle_pkg::front_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] esc_addr_q, esc_addr_d;
  logic          s1_valid_q, s1_valid_d;
  sle_pkg::cmd_t s1_q, s1_d;
  logic          hit_q, hit_d;
  logic [7:0]    rdata_q;

  logic          accept, s1_move, gen;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data;
  logic [31:0]   count_ext, count1_ext, len_ext, idx_ext;

  assign s1_move   = s1_valid_q && !cmd_full_i;
  assign full      = (state_q == sle_pkg::FRONT_ESC2) || (s1_valid_q && cmd_full_i);
  assign accept    = push && !full;
  assign count_ext  = 32'(count_q);
  assign count1_ext = 32'(count_q) + 32'd1;
  assign idx_ext    = 32'(req_i.read_index);
  assign len_ext    = 32'(count_d);
  assign rd_addr    = idx_ext[AW-1:0];

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    esc_addr_d = esc_addr_q;
    gen        = 1'b0;
    hit_d      = hit_q;
    wr_en      = 1'b0;
    wr_addr    = count_ext[AW-1:0];
    wr_data    = req_i.rx_byte;
    rd_en      = 1'b0;
    s1_d       = s1_q;
    if (state_q == sle_pkg::FRONT_ESC2) begin
      // finish the second half of an escape
      wr_en   = 1'b1;
      wr_addr = esc_addr_q;
      wr_data = sle_pkg::CODE_BRACKET;
      state_d = sle_pkg::FRONT_RUN;
    end else if (accept) begin
      s1_d.is_read = 1'b0;
      s1_d.two     = 1'b0;
      s1_d.eol     = 1'b0;
      s1_d.byte0   = req_i.rx_byte;
      s1_d.byte1   = sle_pkg::CODE_BRACKET;
      case (req_i.req_type)
        sle_pkg::REQ_RX: begin
          case (req_i.rx_byte)
            sle_pkg::CODE_BS, sle_pkg::CODE_DEL: begin
              if (count_q != '0) begin
                count_d = count_q - ONE_C;
                gen     = 1'b1;
              end
            end
            sle_pkg::CODE_ESC: begin
              if (count_q < CAP_C) begin
                wr_en      = 1'b1;
                wr_data    = sle_pkg::CODE_CARET;
                s1_d.byte0 = sle_pkg::CODE_CARET;
                gen        = 1'b1;
                if (count_q < CAP_M1) begin
                  count_d    = count_q + TWO_C;
                  s1_d.two   = 1'b1;
                  esc_addr_d = count1_ext[AW-1:0];
                  state_d    = sle_pkg::FRONT_ESC2;
                end else begin
                  count_d = count_q + ONE_C;
                end
              end
            end
            sle_pkg::CODE_LF: begin
              gen = 1'b0;
            end
            sle_pkg::CODE_CR: begin
              s1_d.byte0 = sle_pkg::CODE_LF;
              s1_d.eol   = 1'b1;
              gen        = 1'b1;
            end
            default: begin
              if (count_q < CAP_C) begin
                wr_en   = 1'b1;
                count_d = count_q + ONE_C;
                gen     = 1'b1;
              end
            end
          endcase
        end
        sle_pkg::REQ_CLEAR: begin
          count_d = '0;
        end
        sle_pkg::REQ_READ: begin
          rd_en        = 1'b1;
          hit_d        = idx_ext < count_ext;
          s1_d.is_read = 1'b1;
          gen          = 1'b1;
        end
        default: begin
          gen = 1'b0;
        end
      endcase
      s1_d.line_length = len_ext[6:0];
    end
    if (accept) begin
      s1_valid_d = gen;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sle_pkg::FRONT_RUN;
      count_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    esc_addr_q <= esc_addr_d;
    hit_q      <= hit_d;
    if (accept && gen) begin
      s1_q <= s1_d;
    end
  end

  // Line store: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Merge read data: a read at or past the length returns zero
  always_comb begin
    cmd_o = s1_q;
    if (s1_q.is_read) begin
      cmd_o.byte0 = hit_q ? rdata_q : 8'h00;
    end
  end

  assign cmd_valid_o = s1_move;

endmodule

@@ rtl/sle_cmd_queue.sv @@
// ============================================================================
// sle_cmd_queue: two-entry command queue
// Decouple the front from the back so each can stall on its own.
// ============================================================================
module sle_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  sle_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          empty_o,
  output sle_pkg::cmd_t rd_data_o
);

  sle_pkg::cmd_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign rd_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/sle_back.sv @@
// ============================================================================
// sle_back: result sequencer
// Expand each command into one or two result beats and hold them in the
// output register until taken.
// ============================================================================
module sle_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  sle_pkg::cmd_t cmd_i,
  output logic          cmd_rd_o,
  output logic          empty,
  input  logic          pop,
  output sle_pkg::rsp_t rsp_o
);

  logic          out_valid_q, out_valid_d;
  logic          phase_q, phase_d;
  sle_pkg::rsp_t rsp_q, rsp_d;
  logic          load;

  assign empty = !out_valid_q;
  assign rsp_o = rsp_q;
  assign load  = !out_valid_q || pop;

  always_comb begin
    out_valid_d = out_valid_q;
    phase_d     = phase_q;
    rsp_d       = rsp_q;
    cmd_rd_o    = 1'b0;
    if (load) begin
      out_valid_d       = !cmd_empty_i;
      rsp_d.out_kind    = cmd_i.is_read ? sle_pkg::KIND_READ : sle_pkg::KIND_ECHO;
      rsp_d.line_length = cmd_i.line_length;
      if (phase_q) begin
        // second beat of a two-beat command
        rsp_d.out_byte    = cmd_i.byte1;
        rsp_d.end_of_line = 1'b0;
        rsp_d.last        = 1'b1;
        phase_d           = 1'b0;
        cmd_rd_o          = 1'b1;
      end else begin
        rsp_d.out_byte    = cmd_i.byte0;
        rsp_d.end_of_line = cmd_i.eol;
        rsp_d.last        = !cmd_i.two;
        if (!cmd_empty_i) begin
          phase_d  = cmd_i.two;
          cmd_rd_o = !cmd_i.two;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

endmodule

@@ rtl/serial_line_editor.sv @@
// ============================================================================
// serial_line_editor: line editor with echo for a serial terminal
// Build one text line from received bytes, echo edits, serve line reads.
// ============================================================================
// Usage:
//   Requests enter as a queue write: a beat is taken when push is high and
//   full is low. Results leave as a queue read: the oldest result sits on
//   rsp_o while empty is low and is taken when pop is high.
//   A received byte gives zero or one echo beat; ESC gives up to two ('^',
//   '['); a read gives one beat; clear and line feed give none.
//   Path: a request's first result goes through the intake register (loaded
//   at the edge that accepts it), then the command queue, then the output
//   register.
//   Throughput: one request per cycle while full is low; a two-byte ESC holds
//   full while the front writes the second byte through the single store write
//   port, and its two beats leave one after the other from the output register.
//   Reset empties the line and all queues; the line store itself is not
//   cleared, as no entry below the line length is ever unwritten.
//   When the receiver stalls, the output register holds, the two-entry
//   command queue fills, and then full rises until pop frees space.
// ============================================================================
module serial_line_editor #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  sle_pkg::req_t req_i,
  output logic          empty,
  input  logic          pop,
  output sle_pkg::rsp_t rsp_o
);

  logic          cmd_wr, cmd_full, cmd_rd, cmd_empty;
  sle_pkg::cmd_t cmd_in, cmd_out;

  // Front: classify, keep the line count and the store
  sle_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .req_i      (req_i),
    .cmd_valid_o(cmd_wr),
    .cmd_full_i (cmd_full),
    .cmd_o      (cmd_in)
  );

  // Queue: absorb stalls between front and back
  sle_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (cmd_wr),
    .wr_data_i(cmd_in),
    .full_o   (cmd_full),
    .rd_i     (cmd_rd),
    .empty_o  (cmd_empty),
    .rd_data_o(cmd_out)
  );

  // Back: expand commands into result beats
  sle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_rd_o   (cmd_rd),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp_o)
  );

endmodule

@@ rtl/sle_checker.sv @@
// ============================================================================
// sle_checker: port-level checks of the serial line editor
// Watch the result channel for beats that break the editor's rules.
// ============================================================================
module sle_checker #(
  parameter int LINE_CAPACITY = 64
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          empty,
  input sle_pkg::rsp_t rsp_o
);

  logic [31:0] len_ext;
  assign len_ext = 32'(rsp_o.line_length);

  // No result beat shows once reset has been seen at an edge
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown during reset");

  // A read answers with exactly one beat, never flagged end of line
  a_read_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.out_kind == sle_pkg::KIND_READ) |->
      (rsp_o.last && !rsp_o.end_of_line))
    else $error("read beat not single");

  // End of line is the lone line-feed echo
  a_eol_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.end_of_line) |->
      (rsp_o.out_byte == sle_pkg::CODE_LF && rsp_o.last &&
       rsp_o.out_kind == sle_pkg::KIND_ECHO))
    else $error("end of line on wrong beat");

  // Line length never exceeds the capacity
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (len_ext <= 32'(LINE_CAPACITY)))
    else $error("line length over capacity");

  // A non-final beat is the caret of an escape
  a_first_caret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !rsp_o.last) |-> (rsp_o.out_byte == sle_pkg::CODE_CARET))
    else $error("unexpected non-final beat");

endmodule

bind serial_line_editor sle_checker #(.LINE_CAPACITY(LINE_CAPACITY)) u_checker (.*);

@@ sim/sle_echo_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// sle_echo_checker: result predictor and scoreboard for the serial line editor
// Watch the request and result channels, keep a shadow copy of the line,
// queue the echo and read beats each accepted request should produce, and
// compare every result beat against the oldest expected one.
// ============================================================================
module sle_echo_checker #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          full_i,
  input  sle_pkg::req_t req_i,
  input  logic          empty_i,
  input  logic          pop_i,
  input  sle_pkg::rsp_t rsp_i,
  output int unsigned   mismatches_o,
  output int unsigned   outstanding_o,
  output int unsigned   accepted_o,
  output int unsigned   beats_o,
  output int unsigned   at_capacity_o
);
  import sle_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int AW          = $clog2(LINE_CAPACITY);

  // Shadow line; entries at or above line_len are never read back
  logic [7:0]  line_mem [LINE_CAPACITY];
  logic [6:0]  line_len;
  rsp_t        echo_q [$];
  int unsigned mismatch_cnt;
  int unsigned beat_cnt;
  int unsigned accept_cnt;
  int unsigned capacity_cnt;

  function automatic rsp_t make_beat(input logic kind, input logic [7:0] code,
                                     input logic eol);
    rsp_t b;
    b.out_kind    = kind;
    b.out_byte    = code;
    b.end_of_line = eol;
    b.line_length = '0;
    b.last        = 1'b0;
    return b;
  endfunction

  // Apply one request to the shadow line and queue the beats it produces
  function automatic void edit_line(input req_t r);
    rsp_t beats [2];
    int   n;
    n = 0;
    accept_cnt++;
    if (line_len == LINE_CAPACITY) capacity_cnt++;
    case (r.req_type)
      REQ_RX: begin
        if (r.rx_byte == CODE_BS || r.rx_byte == CODE_DEL) begin
          if (line_len != 0) begin
            line_len--;
            beats[n++] = make_beat(KIND_ECHO, r.rx_byte, 1'b0);
          end
        end else if (r.rx_byte == CODE_ESC) begin
          if (line_len < LINE_CAPACITY) begin
            line_mem[line_len[AW-1:0]] = CODE_CARET;
            line_len++;
            beats[n++] = make_beat(KIND_ECHO, CODE_CARET, 1'b0);
            if (line_len < LINE_CAPACITY) begin
              line_mem[line_len[AW-1:0]] = CODE_BRACKET;
              line_len++;
              beats[n++] = make_beat(KIND_ECHO, CODE_BRACKET, 1'b0);
            end
          end
        end else if (r.rx_byte == CODE_LF) begin
          // line feed is swallowed
        end else if (r.rx_byte == CODE_CR) begin
          beats[n++] = make_beat(KIND_ECHO, CODE_LF, 1'b1);
        end else if (line_len < LINE_CAPACITY) begin
          line_mem[line_len[AW-1:0]] = r.rx_byte;
          line_len++;
          beats[n++] = make_beat(KIND_ECHO, r.rx_byte, 1'b0);
        end
      end
      REQ_CLEAR: line_len = '0;
      REQ_READ: begin
        beats[n++] = make_beat(KIND_READ,
                               (r.read_index < line_len) ? line_mem[r.read_index] : 8'h00,
                               1'b0);
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      beats[k].line_length = line_len;
      beats[k].last        = (k == n - 1);
      echo_q.push_back(beats[k]);
    end
  endfunction

  function automatic void check_beat(input rsp_t got);
    rsp_t want;
    beat_cnt++;
    if (echo_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("%0t: unexpected result beat kind=%0d byte=%02h eol=%0d len=%0d last=%0d",
                 $time, got.out_kind, got.out_byte, got.end_of_line, got.line_length,
                 got.last);
      return;
    end
    want = echo_q.pop_front();
    if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
        got.end_of_line !== want.end_of_line || got.line_length !== want.line_length ||
        got.last !== want.last) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS) begin
        $display("%0t: beat %0d expected kind=%0d byte=%02h eol=%0d len=%0d last=%0d",
                 $time, beat_cnt, want.out_kind, want.out_byte, want.end_of_line,
                 want.line_length, want.last);
        $display("%0t: beat %0d actual   kind=%0d byte=%02h eol=%0d len=%0d last=%0d",
                 $time, beat_cnt, got.out_kind, got.out_byte, got.end_of_line,
                 got.line_length, got.last);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q.delete();
      line_len      = '0;
      mismatch_cnt  = 0;
      beat_cnt      = 0;
      accept_cnt    = 0;
      capacity_cnt  = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
      accepted_o    <= 0;
      beats_o       <= 0;
      at_capacity_o <= 0;
    end else begin
      // Results lag requests, so retire before predicting
      if (pop_i && !empty_i) check_beat(rsp_i);
      if (push_i && !full_i) edit_line(req_i);
      mismatches_o  <= mismatch_cnt;
      outstanding_o <= echo_q.size();
      accepted_o    <= accept_cnt;
      beats_o       <= beat_cnt;
      at_capacity_o <= capacity_cnt;
    end
  end

endmodule

@@ sim/serial_line_editor_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// serial_line_editor_tb: testbench for the serial line editor
// Drive a short directed sequence and then about a thousand random requests
// in plain, fill and edit mixes; random idling on both sides, one long
// receiver hold-off and drain pauses. The checker beside the block predicts
// and compares every result beat.
// ============================================================================
module serial_line_editor_tb;
  import sle_pkg::*;

  localparam int          LINE_CAPACITY = 64;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;   // no request kind, block ignores it
  localparam int unsigned RANDOM_ITEMS  = 1030;
  localparam int unsigned SEGMENT_ITEMS = 96;
  localparam int unsigned STEADY_FROM   = 300;    // no idling on either side here
  localparam int unsigned STEADY_TO     = 450;
  localparam int unsigned HOLD_AT       = 600;    // accepted requests before the hold-off
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned PAUSE_AT      = 800;    // random item where the sender drains
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT   = 100000;

  typedef enum logic [1:0] {
    MIX_PLAIN,
    MIX_FILL,
    MIX_EDIT
  } traffic_mix_e;

  logic clk_i    = 1'b0;
  logic rst_ni   = 1'b0;
  logic push     = 1'b0;
  logic pop      = 1'b0;
  logic steady   = 1'b0;
  req_t req_beat = '0;
  logic full;
  logic empty;
  rsp_t rsp_beat;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned accepted;
  int unsigned beats_checked;
  int unsigned at_capacity;
  int unsigned reads_sent;
  int unsigned clears_sent;
  int unsigned unused_sent;
  int unsigned cycle_count;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  serial_line_editor #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req_beat),
    .empty (empty),
    .pop   (pop),
    .rsp_o (rsp_beat)
  );

  sle_echo_checker #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .req_i        (req_beat),
    .empty_i      (empty),
    .pop_i        (pop),
    .rsp_i        (rsp_beat),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .accepted_o   (accepted),
    .beats_o      (beats_checked),
    .at_capacity_o(at_capacity)
  );

  // --------------------------------------------------------------------------
  // Beat builders; fields the request kind ignores get random values so that
  // every bit still toggles
  // --------------------------------------------------------------------------
  function automatic req_t rx_beat(input logic [7:0] code);
    req_t b;
    b.req_type   = REQ_RX;
    b.rx_byte    = code;
    b.read_index = 6'($urandom_range(63));
    return b;
  endfunction

  function automatic req_t read_beat(input logic [5:0] idx);
    req_t b;
    b.req_type   = REQ_READ;
    b.rx_byte    = 8'($urandom_range(255));
    b.read_index = idx;
    return b;
  endfunction

  // Pick one request; the mix sets how hard the line is pushed toward full
  // or worn down by erases and clears
  function automatic req_t random_request(input traffic_mix_e mix);
    req_t        b;
    int unsigned erase_pct;
    int unsigned esc_pct;
    int unsigned clear_pct;
    int unsigned pick;
    b.req_type   = REQ_RX;
    b.rx_byte    = 8'($urandom_range(255));
    b.read_index = 6'($urandom_range(63));
    case (mix)
      MIX_FILL: begin
        erase_pct = 4;
        esc_pct   = 15;
        clear_pct = 0;
      end
      MIX_EDIT: begin
        erase_pct = 25;
        esc_pct   = 8;
        clear_pct = 6;
      end
      default: begin
        erase_pct = 10;
        esc_pct   = 8;
        clear_pct = 3;
      end
    endcase
    pick = $urandom_range(99);
    if (pick < 2) begin
      b.req_type = REQ_UNUSED;
    end else if (pick < 2 + clear_pct) begin
      b.req_type = REQ_CLEAR;
    end else if (pick < 14 + clear_pct) begin
      b.req_type = REQ_READ;
    end else begin
      // Bias the received byte toward the control codes
      pick = $urandom_range(99);
      if (pick < erase_pct)
        b.rx_byte = pick[0] ? CODE_DEL : CODE_BS;
      else if (pick < erase_pct + esc_pct)
        b.rx_byte = CODE_ESC;
      else if (pick < erase_pct + esc_pct + 5)
        b.rx_byte = CODE_CR;
      else if (pick < erase_pct + esc_pct + 8)
        b.rx_byte = CODE_LF;
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one beat and hold it until the block takes it. Idle first at random
  // unless the steady window is open. push stays high between back-to-back
  // beats, so it is never lowered and raised in the same step.
  task automatic send_beat(input req_t beat);
    while (!steady && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    req_beat <= beat;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    case (beat.req_type)
      REQ_READ:   reads_sent++;
      REQ_CLEAR:  clears_sent++;
      REQ_UNUSED: unused_sent++;
      default: ;
    endcase
  endtask

  // Drop push and hold until every expected result beat has come back
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: pop at random, always pop in the steady window, and hold
  // off for a long stretch once so the command queue fills and full rises
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (steady) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 12);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d result beats still expected",
             cycle_count, outstanding);
    $display("serial_line_editor_tb NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin
    req_t         odd_beat;
    req_t         beat;
    traffic_mix_e mix;
    int unsigned  rand_sent;
    int unsigned  seg_left;

    reads_sent  = 0;
    clears_sent = 0;
    unused_sent = 0;

    // Hold reset, then release it once for the whole run
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reads and erases on an empty line, the ignored and
    // echoed line endings, extreme bytes, the ESC pair, read-back below and
    // past the length, clear, and the unused request kind
    send_beat(read_beat(6'd0));
    send_beat(read_beat(6'd63));
    send_beat(rx_beat(CODE_BS));
    send_beat(rx_beat(CODE_DEL));
    send_beat(rx_beat(CODE_LF));
    send_beat(rx_beat(CODE_CR));
    send_beat(rx_beat(8'h00));
    send_beat(rx_beat(8'hff));
    send_beat(rx_beat(8'h41));
    send_beat(rx_beat(CODE_ESC));
    send_beat(read_beat(6'd0));
    send_beat(read_beat(6'd1));
    send_beat(read_beat(6'd4));
    send_beat(read_beat(6'd5));
    send_beat(rx_beat(CODE_BS));
    send_beat(rx_beat(CODE_DEL));
    send_beat(read_beat(6'd3));
    odd_beat.req_type   = REQ_UNUSED;
    odd_beat.rx_byte    = 8'hff;
    odd_beat.read_index = 6'h3f;
    send_beat(odd_beat);
    odd_beat.req_type   = REQ_CLEAR;
    odd_beat.rx_byte    = 8'h00;
    odd_beat.read_index = 6'h00;
    send_beat(odd_beat);
    send_beat(read_beat(6'd0));
    send_beat(rx_beat(CODE_CR));
    send_beat(rx_beat(8'h7e));

    // Let the directed results come home before the random traffic
    wait_drained();

    // Random part, in segments of one traffic mix; start with a fill so the
    // full-line cases show up early
    rand_sent = 0;
    seg_left  = SEGMENT_ITEMS;
    mix       = MIX_FILL;
    while (rand_sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        mix      = traffic_mix_e'($urandom_range(2));
        seg_left = SEGMENT_ITEMS;
      end
      steady <= (rand_sent >= STEADY_FROM && rand_sent < STEADY_TO);
      if (rand_sent == PAUSE_AT) wait_drained();
      beat = random_request(mix);
      send_beat(beat);
      // Ignored requests do not count toward the item budget
      if (beat.req_type != REQ_UNUSED) begin
        rand_sent++;
        seg_left--;
      end
    end

    // Drain, then give the pipeline time to show any stray beat
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (%0d reads, %0d clears, %0d unused kind), %0d beats checked",
             accepted, reads_sent, clears_sent, unused_sent, beats_checked);
    $display("line at capacity on %0d requests; %0d mismatches, %0d beats missing",
             at_capacity, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("serial_line_editor_tb OK");
    end else begin
      $display("serial_line_editor_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sle_pkg.sv
rtl/sle_front.sv
rtl/sle_cmd_queue.sv
rtl/sle_back.sv
rtl/serial_line_editor.sv
rtl/sle_checker.sv
sim/sle_echo_checker.sv
sim/serial_line_editor_tb.sv
